// ===== src/mcw_pkg.sv =====
package mcw_pkg;

  // symbol alphabet: one need entry per byte value
  localparam int SYM_W    = 8;
  localparam int ALPHABET = 2 ** SYM_W;

  localparam int MAX_TEXT_DEF = 1024;

  // fixed result field widths
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  // control group for the need table
  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    logic             clr;
  } nt_ctrl_t;

endpackage

// ===== src/mcw_if.sv =====
interface mcw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [mcw_pkg::SYM_W-1:0] symbol;
  logic                     last;

  modport source (output valid, action, symbol, last, input ready);
  modport sink   (input valid, action, symbol, last, output ready);
endinterface

interface mcw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mcw_pkg::START_W-1:0] window_start;
  logic [mcw_pkg::LEN_W-1:0]   window_length;
  logic                        overflow;

  modport source (output valid, found, window_start, window_length, overflow, input ready);
  modport sink   (input valid, found, window_start, window_length, overflow, output ready);
endinterface

// ===== src/mcw_need_table.sv =====
// Per-symbol need count, registered read; valid bit doubles as in-pattern flag.
module mcw_need_table #(
  parameter int NW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mcw_pkg::nt_ctrl_t      ctrl,
  input  logic signed [NW-1:0]   wr_data,
  output logic                   rd_hit,
  output logic signed [NW-1:0]   rd_need
);

  logic [NW-1:0]                mem [mcw_pkg::ALPHABET];
  logic [mcw_pkg::ALPHABET-1:0] vld;
  logic [NW-1:0]                mem_q;
  logic                         vld_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      mem_q <= mem[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        vld[ctrl.wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        vld_q <= vld[ctrl.rd_addr];
      end
    end
  end

  // entry never written this query reads as zero
  assign rd_hit  = vld_q;
  assign rd_need = vld_q ? $signed(mem_q) : '0;

endmodule

// ===== src/mcw_text_store.sv =====
// Text symbol store, one write and one registered read port.
module mcw_text_store #(
  parameter int MAX_TEXT = mcw_pkg::MAX_TEXT_DEF,
  parameter int AW       = $clog2(MAX_TEXT)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mcw_pkg::SYM_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [mcw_pkg::SYM_W-1:0] rd_data
);

  logic [mcw_pkg::SYM_W-1:0] mem [MAX_TEXT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/minimum_covering_window.sv =====
// Steps: a pattern beat reads its need and writes need + 1 back; a text beat writes
// need - 1 back, then takes left-edge steps, and a last beat then posts the result.
// Left-edge steps total at most the text length per query. A beat is taken only in idle.
// Rate is set by the read-modify-write of the need table.
// Synchronous reset clears all control state and the in-pattern bits at once;
// the text store holds no reset and needs no clearing pass.
module minimum_covering_window #(
  parameter int MAX_TEXT = mcw_pkg::MAX_TEXT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mcw_in_if.sink    item,
  mcw_out_if.source result
);

  localparam int AW = $clog2(MAX_TEXT);       // text store address
  localparam int CW = $clog2(MAX_TEXT + 1);   // counts up to MAX_TEXT
  localparam int NW = CW + 1;                 // signed need, +/- MAX_TEXT
  localparam int LW = $clog2(MAX_TEXT + 2);   // best length incl. "none"
  localparam logic [LW-1:0] LEN_NONE = LW'(MAX_TEXT + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_TEXT);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a beat
    S_P_MOD,   // pattern: need + 1 written back
    S_T_MOD,   // text: need - 1 written back, right edge grows
    S_LOOP,    // test window; fetch left symbol
    S_L_SYM,   // left symbol arrives; fetch its need
    S_L_MOD,   // need + 1 written back, left edge grows
    S_FINISH   // post result, clear for next query
  } state_t;

  state_t state;

  // window bookkeeping
  logic [CW-1:0]   left;
  logic [CW-1:0]   right;
  logic [CW-1:0]   missing;
  logic [CW-1:0]   plen;
  logic [AW-1:0]   best_start;
  logic [LW-1:0]   best_len;
  logic            ovf;

  // latched beat
  logic [mcw_pkg::SYM_W-1:0] sym;
  logic                      last;
  logic [mcw_pkg::SYM_W-1:0] ls;

  // output register
  logic                        out_valid;
  logic                        out_found;
  logic [mcw_pkg::START_W-1:0] out_start;
  logic [mcw_pkg::LEN_W-1:0]   out_len;
  logic                        out_ovf;

  // memory ports
  mcw_pkg::nt_ctrl_t         nt_ctrl;
  logic signed [NW-1:0]      nt_wr_data;
  logic                      nt_hit;
  logic signed [NW-1:0]      nt_need;
  logic signed [NW-1:0]      need_inc;
  logic signed [NW-1:0]      need_dec;
  logic                      ts_wr_en;
  logic                      ts_rd_en;
  logic [mcw_pkg::SYM_W-1:0] ts_rd_data;

  logic accept;
  logic out_free;
  logic win_ok;
  logic [CW-1:0] span;
  logic          found_now;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  assign need_inc = nt_need + NW'(1);
  assign need_dec = nt_need - NW'(1);

  // shrink the window while everything is covered
  assign win_ok = (plen != '0) && (missing == '0) && (left < right);
  assign span   = right - left;

  assign found_now = (best_len <= LW'(MAX_TEXT));

  // memory port control
  always_comb begin
    nt_ctrl    = '0;
    nt_wr_data = need_inc;
    ts_wr_en   = 1'b0;
    ts_rd_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          nt_ctrl.rd_addr = item.symbol;
          if (item.action == mcw_pkg::ACT_PATTERN) begin
            nt_ctrl.rd_en = (plen < CNT_MAX);
          end else begin
            nt_ctrl.rd_en = (right < CNT_MAX);
            ts_wr_en      = (right < CNT_MAX);
          end
        end
      end
      S_P_MOD: begin
        nt_ctrl.wr_en   = 1'b1;
        nt_ctrl.wr_addr = sym;
      end
      S_T_MOD: begin
        nt_ctrl.wr_en   = nt_hit;
        nt_ctrl.wr_addr = sym;
        nt_wr_data      = need_dec;
      end
      S_LOOP: begin
        ts_rd_en = win_ok;
      end
      S_L_SYM: begin
        nt_ctrl.rd_en   = 1'b1;
        nt_ctrl.rd_addr = ts_rd_data;
      end
      S_L_MOD: begin
        nt_ctrl.wr_en   = nt_hit;
        nt_ctrl.wr_addr = ls;
      end
      S_FINISH: begin
        nt_ctrl.clr = out_free;
      end
      default: begin
        nt_ctrl = '0;
      end
    endcase
  end

  mcw_need_table #(
    .NW (NW)
  ) u_need (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (nt_ctrl),
    .wr_data (nt_wr_data),
    .rd_hit  (nt_hit),
    .rd_need (nt_need)
  );

  mcw_text_store #(
    .MAX_TEXT (MAX_TEXT),
    .AW       (AW)
  ) u_text (
    .clk     (clk),
    .wr_en   (ts_wr_en),
    .wr_addr (right[AW-1:0]),
    .wr_data (item.symbol),
    .rd_en   (ts_rd_en),
    .rd_addr (left[AW-1:0]),
    .rd_data (ts_rd_data)
  );

  // sequencer, window counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      left       <= '0;
      right      <= '0;
      missing    <= '0;
      plen       <= '0;
      best_start <= '0;
      best_len   <= LEN_NONE;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // in S_FINISH the slot is always refilled, so only drain elsewhere
      if (out_valid && result.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sym  <= item.symbol;
            last <= item.last;
            if (item.action == mcw_pkg::ACT_PATTERN) begin
              if (plen < CNT_MAX) begin
                plen  <= plen + CW'(1);
                state <= S_P_MOD;
              end else begin
                ovf <= 1'b1;
              end
            end else if (right < CNT_MAX) begin
              state <= S_T_MOD;
            end else begin
              // beyond the store: dropped, but a last mark still reports
              ovf <= 1'b1;
              if (item.last) begin
                state <= S_FINISH;
              end
            end
          end
        end
        S_P_MOD: begin
          if (need_inc > 0) begin
            missing <= missing + CW'(1);
          end
          state <= S_IDLE;
        end
        S_T_MOD: begin
          if (nt_hit && (nt_need > 0)) begin
            missing <= missing - CW'(1);
          end
          right <= right + CW'(1);
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (win_ok) begin
            if (best_len > LW'(span)) begin
              best_start <= left[AW-1:0];
              best_len   <= LW'(span);
            end
            state <= S_L_SYM;
          end else if (last) begin
            state <= S_FINISH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_L_SYM: begin
          ls    <= ts_rd_data;
          state <= S_L_MOD;
        end
        S_L_MOD: begin
          if (nt_hit && (need_inc > 0)) begin
            missing <= missing + CW'(1);
          end
          left  <= left + CW'(1);
          state <= S_LOOP;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_found  <= found_now;
            out_start  <= found_now ? mcw_pkg::START_W'(best_start) : '0;
            out_len    <= found_now ? mcw_pkg::LEN_W'(best_len) : '0;
            out_ovf    <= ovf;
            left       <= '0;
            right      <= '0;
            missing    <= '0;
            plen       <= '0;
            best_start <= '0;
            best_len   <= LEN_NONE;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.found         = out_found;
  assign result.window_start  = out_start;
  assign result.window_length = out_len;
  assign result.overflow      = out_ovf;

endmodule
